@@ rtl/core/hsvrgb_pkg.sv @@
// shared constants, types and the sector order table for the hsv to rgb converter
// no dependencies
package hsvrgb_pkg;

  localparam int HueWidth   = 16;
  localparam int SatWidth   = 9;
  localparam int BriWidth   = 9;
  localparam int ChanWidth  = 8;
  localparam int NumChan    = 3;
  localparam int NumStages  = 5;

  // one sector is 60 degrees at 128 codes per degree
  localparam int SectorUnits = 7680;
  localparam int PairUnits   = 2 * SectorUnits;
  localparam int NumSectors  = 6;
  // largest hue code divided by one sector
  localparam int SectorSpan  = ((1 << HueWidth) - 1) / SectorUnits;

  localparam int SvWidth     = SatWidth + BriWidth;
  localparam int TWidth      = 13;
  localparam int CompWidth   = 31;
  localparam int OffWidth    = 32;
  localparam int SumWidth    = 33;

  typedef enum logic [1:0] {
    COMP_ZERO,
    COMP_CHROMA,
    COMP_MID
  } comp_e;

  typedef comp_e comp_row_t [NumChan];

  // component order (red, green, blue) for each hue sector
  function automatic comp_row_t order_row(logic [2:0] sector);
    comp_row_t row;
    case (sector)
      3'd0: row = '{COMP_CHROMA, COMP_MID, COMP_ZERO};
      3'd1: row = '{COMP_MID, COMP_CHROMA, COMP_ZERO};
      3'd2: row = '{COMP_ZERO, COMP_CHROMA, COMP_MID};
      3'd3: row = '{COMP_ZERO, COMP_MID, COMP_CHROMA};
      3'd4: row = '{COMP_MID, COMP_ZERO, COMP_CHROMA};
      3'd5: row = '{COMP_CHROMA, COMP_ZERO, COMP_MID};
      default: row = '{COMP_ZERO, COMP_ZERO, COMP_ZERO};
    endcase
    return row;
  endfunction

endpackage

@@ rtl/core/hsvrgb_if.sv @@
// valid/ready stream interfaces for hsv input and rgb output transactions
// depends on hsvrgb_pkg
interface hsvrgb_hsv_if;
  import hsvrgb_pkg::*;

  logic                valid;
  logic                ready;
  logic [HueWidth-1:0] hue;
  logic [SatWidth-1:0] saturation;
  logic [BriWidth-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvrgb_rgb_if;
  import hsvrgb_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ChanWidth-1:0] red;
  logic [ChanWidth-1:0] green;
  logic [ChanWidth-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

@@ rtl/core/hsv_to_rgb_converter.sv @@
// hsv to rgb converter, five register stages, one transaction per cycle sustained while the output is ready
// throughput: 1 transaction per cycle; a full stage holds only while the next cannot load
// reset: asynchronous active-low reset clears the stage valid bits, payload is not reset
// depends on hsvrgb_pkg, hsvrgb_if, hsvrgb_hue_unit, hsvrgb_chroma_unit, hsvrgb_channel_unit
module hsv_to_rgb_converter (
  input  logic  clk_i,
  input  logic  rst_ni,
  hsvrgb_hsv_if.sink   hsv_i,
  hsvrgb_rgb_if.source rgb_o
);
  import hsvrgb_pkg::*;

  logic [NumStages-1:0]                valid_q;
  logic [NumStages-1:0]                valid_d;
  logic [NumStages-1:0]                stage_en;
  logic [TWidth-1:0]                   t;
  logic [2:0]                          sector;
  logic [CompWidth-1:0]                chroma;
  logic [CompWidth-1:0]                mid;
  logic signed [OffWidth-1:0]          offset;
  logic [NumChan-1:0][ChanWidth-1:0]   rgb;
  logic                                in_fire;
  logic                                out_fire;

  // a stage may load when it is empty or the stage after it moves on
  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || rgb_o.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      stage_en[i] = !valid_q[i] || stage_en[i+1];
    end
    valid_d = valid_q;
    if (stage_en[0]) begin
      valid_d[0] = hsv_i.valid;
    end
    for (int i = 1; i < NumStages; i++) begin
      if (stage_en[i]) begin
        valid_d[i] = valid_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign hsv_i.ready = stage_en[0];
  assign in_fire     = hsv_i.valid && hsv_i.ready;
  assign out_fire    = rgb_o.valid && rgb_o.ready;

  hsvrgb_hue_unit u_hue (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .hue_i      (hsv_i.hue),
    .t_o        (t),
    .sector_o   (sector)
  );

  hsvrgb_chroma_unit u_chroma (
    .clk_i        (clk_i),
    .stage_en_i   (stage_en),
    .saturation_i (hsv_i.saturation),
    .brightness_i (hsv_i.brightness),
    .t_i          (t),
    .chroma_o     (chroma),
    .mid_o        (mid),
    .offset_o     (offset)
  );

  hsvrgb_channel_unit u_channel (
    .clk_i      (clk_i),
    .stage_en_i (stage_en),
    .sector_i   (sector),
    .chroma_i   (chroma),
    .mid_i      (mid),
    .offset_i   (offset),
    .rgb_o      (rgb)
  );

  assign rgb_o.valid = valid_q[NumStages-1];
  assign rgb_o.red   = rgb[0];
  assign rgb_o.green = rgb[1];
  assign rgb_o.blue  = rgb[2];

  // input only backs up when every stage is occupied
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> (&valid_q))
    else $error("input stalled with an empty stage");

  // occupancy grows by one on an input-only transaction
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_fire) |=> ($countones(valid_q) == $past($countones(valid_q)) + 1))
    else $error("transaction lost on entry");

  // occupancy shrinks by one on an output-only transaction
  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_fire && out_fire) |=> ($countones(valid_q) + 1 == $past($countones(valid_q))))
    else $error("transaction lost or repeated in the pipeline");

  // with no traffic, or with one transaction in and one out, the occupancy holds
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire == out_fire) |=> ($countones(valid_q) == $past($countones(valid_q))))
    else $error("occupancy changed without matching transactions");

endmodule

@@ rtl/core/hsvrgb_hue_unit.sv @@
// hue path: sector index, position inside a sector pair and the ramp term t
// depends on hsvrgb_pkg
module hsvrgb_hue_unit (
  input  logic                               clk_i,
  input  logic [hsvrgb_pkg::NumStages-1:0]   stage_en_i,
  input  logic [hsvrgb_pkg::HueWidth-1:0]    hue_i,
  output logic [hsvrgb_pkg::TWidth-1:0]      t_o,
  output logic [2:0]                         sector_o
);
  import hsvrgb_pkg::*;

  logic [3:0]          quot;
  logic [2:0]          sector_d;
  logic [HueWidth-1:0] hue_q;
  logic [2:0]          pair_q;
  logic [2:0]          sector1_q;
  logic [2:0]          sector2_q;
  logic [2:0]          sector3_q;
  logic [HueWidth-1:0] pair_base;
  logic [13:0]         pos;
  logic [TWidth-1:0]   fold;
  logic [TWidth-1:0]   t_d;
  logic [TWidth-1:0]   t_q;

  // hue div sector by parallel threshold compares
  always_comb begin
    quot = '0;
    for (int k = 1; k <= SectorSpan; k++) begin
      if (hue_i >= HueWidth'(k * SectorUnits)) begin
        quot = quot + 4'd1;
      end
    end
    sector_d = (quot >= 4'(NumSectors)) ? 3'(quot - 4'(NumSectors)) : 3'(quot);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      hue_q     <= hue_i;
      pair_q    <= quot[3:1];
      sector1_q <= sector_d;
    end
  end

  // t = sector - |p - sector|, p = hue mod two sectors
  always_comb begin
    pair_base = HueWidth'(pair_q * PairUnits);
    pos       = 14'(hue_q - pair_base);
    if (pos >= 14'(SectorUnits)) begin
      fold = TWidth'(pos - 14'(SectorUnits));
    end else begin
      fold = TWidth'(14'(SectorUnits) - pos);
    end
    t_d = TWidth'(SectorUnits) - fold;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      t_q       <= t_d;
      sector2_q <= sector1_q;
    end
    if (stage_en_i[2]) begin
      sector3_q <= sector2_q;
    end
  end

  assign t_o      = t_q;
  assign sector_o = sector3_q;

endmodule

@@ rtl/core/hsvrgb_chroma_unit.sv @@
// chroma s*v, offset v-c and the middle component c*t, all scaled by one sector
// depends on hsvrgb_pkg
module hsvrgb_chroma_unit (
  input  logic                                    clk_i,
  input  logic [hsvrgb_pkg::NumStages-1:0]        stage_en_i,
  input  logic [hsvrgb_pkg::SatWidth-1:0]         saturation_i,
  input  logic [hsvrgb_pkg::BriWidth-1:0]         brightness_i,
  input  logic [hsvrgb_pkg::TWidth-1:0]           t_i,
  output logic [hsvrgb_pkg::CompWidth-1:0]        chroma_o,
  output logic [hsvrgb_pkg::CompWidth-1:0]        mid_o,
  output logic signed [hsvrgb_pkg::OffWidth-1:0]  offset_o
);
  import hsvrgb_pkg::*;

  localparam logic signed [OffWidth-1:0] SectorUnitsS = OffWidth'(SectorUnits);

  logic [SvWidth-1:0]          sv1_q;
  logic [BriWidth-1:0]         bri_q;
  logic [SvWidth-1:0]          sv2_q;
  logic signed [SvWidth:0]     k_d;
  logic signed [SvWidth:0]     k_q;
  logic signed [OffWidth-1:0]  k_ext;
  logic [CompWidth-1:0]        chroma_d;
  logic [CompWidth-1:0]        mid_d;
  logic signed [OffWidth-1:0]  offset_d;
  logic [CompWidth-1:0]        chroma_q;
  logic [CompWidth-1:0]        mid_q;
  logic signed [OffWidth-1:0]  offset_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      sv1_q <= SvWidth'(saturation_i) * SvWidth'(brightness_i);
      bri_q <= brightness_i;
    end
  end

  // v*256 - s*v, negative when saturation is above one
  assign k_d = signed'({2'b00, bri_q, 8'h00}) - signed'({1'b0, sv1_q});

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      sv2_q <= sv1_q;
      k_q   <= k_d;
    end
  end

  always_comb begin
    k_ext    = OffWidth'(k_q);
    chroma_d = CompWidth'(sv2_q) * CompWidth'(SectorUnits);
    mid_d    = CompWidth'(sv2_q) * CompWidth'(t_i);
    offset_d = k_ext * SectorUnitsS;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      chroma_q <= chroma_d;
      mid_q    <= mid_d;
      offset_q <= offset_d;
    end
  end

  assign chroma_o = chroma_q;
  assign mid_o    = mid_q;
  assign offset_o = offset_q;

endmodule

@@ rtl/core/hsvrgb_channel_unit.sv @@
// per channel: pick the component for the sector, add offset, scale by 255 and clamp
// depends on hsvrgb_pkg
module hsvrgb_channel_unit (
  input  logic                                              clk_i,
  input  logic [hsvrgb_pkg::NumStages-1:0]                  stage_en_i,
  input  logic [2:0]                                        sector_i,
  input  logic [hsvrgb_pkg::CompWidth-1:0]                  chroma_i,
  input  logic [hsvrgb_pkg::CompWidth-1:0]                  mid_i,
  input  logic signed [hsvrgb_pkg::OffWidth-1:0]            offset_i,
  output logic [hsvrgb_pkg::NumChan-1:0][hsvrgb_pkg::ChanWidth-1:0] rgb_o
);
  import hsvrgb_pkg::*;

  comp_row_t                     row;
  logic [CompWidth-1:0]          comp [NumChan];
  logic signed [SumWidth-1:0]    sum_d [NumChan];
  logic signed [SumWidth-1:0]    sum_q [NumChan];
  logic [36:0]                   prod [NumChan];
  logic [11:0]                   quot [NumChan];
  logic [NumChan-1:0][ChanWidth-1:0] rgb_d;
  logic [NumChan-1:0][ChanWidth-1:0] rgb_q;

  always_comb begin
    row = order_row(sector_i);
    for (int i = 0; i < NumChan; i++) begin
      case (row[i])
        COMP_CHROMA: comp[i] = chroma_i;
        COMP_MID:    comp[i] = mid_i;
        default:     comp[i] = '0;
      endcase
      sum_d[i] = signed'({2'b00, comp[i]}) + SumWidth'(offset_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      sum_q <= sum_d;
    end
  end

  // 255 / (65536 * 7680) reduces to 17 / 2^25
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      prod[i] = {1'b0, sum_q[i][31:0], 4'h0} + 37'(sum_q[i][31:0]);
      quot[i] = prod[i][36:25];
      if (sum_q[i][SumWidth-1]) begin
        rgb_d[i] = '0;
      end else if (|quot[i][11:8]) begin
        rgb_d[i] = '1;
      end else begin
        rgb_d[i] = quot[i][7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      rgb_q <= rgb_d;
    end
  end

  assign rgb_o = rgb_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for hsv_to_rgb_converter: directed colors, random streams and stalls
// depends on hsvrgb_pkg, hsvrgb_if and the converter rtl
module tb_top;
  import hsvrgb_pkg::*;

  localparam int     CycleLimit   = 200000;
  localparam int     RxHoldCycles = 80;
  localparam int     MaxPrinted   = 40;
  localparam longint LevelDenom   = longint'(65536) * SectorUnits;

  typedef struct packed {
    logic [HueWidth-1:0] hue;
    logic [SatWidth-1:0] saturation;
    logic [BriWidth-1:0] brightness;
  } hsv_item_t;

  typedef struct packed {
    logic [ChanWidth-1:0] red;
    logic [ChanWidth-1:0] green;
    logic [ChanWidth-1:0] blue;
  } rgb_item_t;

  logic clk_i;
  logic rst_ni;

  hsvrgb_hsv_if hsv_if ();
  hsvrgb_rgb_if rgb_if ();

  hsv_to_rgb_converter i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv_if),
    .rgb_o  (rgb_if)
  );

  rgb_item_t expected_rgb_q [$];
  int        error_cnt;
  int        sent_cnt;
  int        checked_cnt;
  int        off_nominal_cnt;
  int        cycle_cnt;
  bit        tx_idle_on;
  logic      rx_idle_on;
  logic      rx_hold_req;
  logic      rx_hold_ack;
  int        rx_hold_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni            = 1'b0;
    hsv_if.valid      = 1'b0;
    hsv_if.hue        = '0;
    hsv_if.saturation = '0;
    hsv_if.brightness = '0;
    rgb_if.ready      = 1'b0;
    rx_idle_on        = 1'b1;
    rx_hold_req       = 1'b0;
    rx_hold_ack       = 1'b0;
    rx_hold_left      = 0;
    tx_idle_on        = 1'b1;
    cycle_cnt         = 0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_rgb_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // negative totals clip to zero, overlarge ones to full scale
  function automatic logic [ChanWidth-1:0] to_level(input longint total);
    longint q;
    if (total < 0) return '0;
    q = (total * 255) / LevelDenom;
    if (q > 255) return 8'd255;
    return q[ChanWidth-1:0];
  endfunction

  function automatic rgb_item_t predict_rgb(input hsv_item_t item);
    int        sector;
    int        pos;
    int        fold;
    int        ramp;
    longint    sv;
    longint    chroma_n;
    longint    mid_n;
    longint    off_n;
    longint    total;
    comp_e     pick [NumChan];
    rgb_item_t res;
    sector = (int'(item.hue) / SectorUnits) % NumSectors;
    pos    = int'(item.hue) % PairUnits;
    fold   = (pos >= SectorUnits) ? pos - SectorUnits : SectorUnits - pos;
    ramp   = SectorUnits - fold;
    sv       = longint'(item.saturation) * longint'(item.brightness);
    chroma_n = sv * SectorUnits;
    mid_n    = sv * ramp;
    off_n    = (longint'(item.brightness) * 256 - sv) * SectorUnits;
    case (sector)
      0: pick = '{COMP_CHROMA, COMP_MID, COMP_ZERO};
      1: pick = '{COMP_MID, COMP_CHROMA, COMP_ZERO};
      2: pick = '{COMP_ZERO, COMP_CHROMA, COMP_MID};
      3: pick = '{COMP_ZERO, COMP_MID, COMP_CHROMA};
      4: pick = '{COMP_MID, COMP_ZERO, COMP_CHROMA};
      default: pick = '{COMP_CHROMA, COMP_ZERO, COMP_MID};
    endcase
    for (int k = 0; k < NumChan; k++) begin
      case (pick[k])
        COMP_CHROMA: total = chroma_n + off_n;
        COMP_MID:    total = mid_n + off_n;
        default:     total = off_n;
      endcase
      case (k)
        0: res.red = to_level(total);
        1: res.green = to_level(total);
        default: res.blue = to_level(total);
      endcase
    end
    return res;
  endfunction

  task automatic report_error(input string msg);
    error_cnt++;
    if (error_cnt <= MaxPrinted) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // input and output transactions are handled in one process so the queue order is fixed
  always @(posedge clk_i) begin
    rgb_item_t want;
    hsv_item_t got_in;
    if (rst_ni) begin
      if (hsv_if.valid && hsv_if.ready) begin
        got_in = '{hue: hsv_if.hue, saturation: hsv_if.saturation,
                   brightness: hsv_if.brightness};
        expected_rgb_q.insert(expected_rgb_q.size(), predict_rgb(got_in));
        if (got_in.hue >= NumSectors * SectorUnits || got_in.saturation > 256 ||
            got_in.brightness > 256) off_nominal_cnt++;
      end
      if (rgb_if.valid && rgb_if.ready) begin
        checked_cnt++;
        if (expected_rgb_q.size() == 0) begin
          report_error($sformatf("result %0d with no transaction pending", checked_cnt));
        end else begin
          want = expected_rgb_q.pop_front();
          if (rgb_if.red !== want.red)
            report_error($sformatf("result %0d red %0d, expected %0d", checked_cnt,
                                   rgb_if.red, want.red));
          if (rgb_if.green !== want.green)
            report_error($sformatf("result %0d green %0d, expected %0d", checked_cnt,
                                   rgb_if.green, want.green));
          if (rgb_if.blue !== want.blue)
            report_error($sformatf("result %0d blue %0d, expected %0d", checked_cnt,
                                   rgb_if.blue, want.blue));
        end
      end
    end
  end

  // output side: random ready, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack  <= rx_hold_req;
      rx_hold_left <= RxHoldCycles;
      rgb_if.ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      rgb_if.ready <= 1'b0;
    end else if (rx_idle_on) begin
      rgb_if.ready <= ($urandom_range(99) >= 14);
    end else begin
      rgb_if.ready <= 1'b1;
    end
  end

  task automatic send_hsv(input hsv_item_t item);
    while (tx_idle_on && $urandom_range(99) < 14) begin
      hsv_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    hsv_if.valid      <= 1'b1;
    hsv_if.hue        <= item.hue;
    hsv_if.saturation <= item.saturation;
    hsv_if.brightness <= item.brightness;
    @(posedge clk_i);
    while (!hsv_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  task automatic send_color(input int hue, input int sat, input int bri);
    hsv_item_t item;
    item.hue        = hue[HueWidth-1:0];
    item.saturation = sat[SatWidth-1:0];
    item.brightness = bri[BriWidth-1:0];
    send_hsv(item);
  endtask

  // nominal colors most of the time, some on sector edges, full field range when wide
  function automatic hsv_item_t random_hsv(input bit wide);
    hsv_item_t item;
    int        edge_hue;
    if (wide) begin
      item.hue        = HueWidth'($urandom_range(16'hffff));
      item.saturation = SatWidth'($urandom_range(511));
      item.brightness = BriWidth'($urandom_range(511));
    end else begin
      if ($urandom_range(7) == 0) begin
        edge_hue = $urandom_range(NumSectors) * SectorUnits + $urandom_range(2) - 1;
        if (edge_hue < 0) edge_hue = 0;
        if (edge_hue > NumSectors * SectorUnits - 1) edge_hue = NumSectors * SectorUnits - 1;
        item.hue = edge_hue[HueWidth-1:0];
      end else begin
        item.hue = HueWidth'($urandom_range(NumSectors * SectorUnits - 1));
      end
      item.saturation = SatWidth'($urandom_range(256));
      item.brightness = BriWidth'($urandom_range(256));
    end
    return item;
  endfunction

  // stop offering, wait for every outstanding result, then idle with the input off
  task automatic drain_results();
    hsv_if.valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk_i);
    repeat (NumStages + 5) @(posedge clk_i);
  endtask

  task automatic test_directed();
    int hues [13] = '{0, 3840, 7679, 7680, 11520, 15359, 15360, 23040, 30720, 38400,
                      46079, 46080, 65535};
    foreach (hues[k]) send_color(hues[k], 256, 256);
    send_color(0, 0, 0);
    send_color(5000, 0, 256);
    send_color(20000, 256, 0);
    send_color(65535, 511, 511);
    send_color(30000, 511, 256);
    send_color(40000, 256, 511);
    send_color(12345, 128, 200);
    send_color(1, 1, 1);
    send_color(50000, 300, 100);
    drain_results();
  endtask

  task automatic test_random_nominal(input int count);
    for (int n = 0; n < count; n++) send_hsv(random_hsv($urandom_range(9) == 0));
    drain_results();
  endtask

  task automatic test_no_idle(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    for (int n = 0; n < count; n++) send_hsv(random_hsv(1'b0));
    drain_results();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // output held off while input keeps offering, so the pipe fills and stalls its input
  task automatic test_backpressure(input int count);
    tx_idle_on = 1'b0;
    rx_hold_req <= ~rx_hold_req;
    for (int n = 0; n < count; n++) send_hsv(random_hsv(1'b0));
    drain_results();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_wide(input int count);
    for (int n = 0; n < count; n++) send_hsv(random_hsv(1'b1));
    drain_results();
  endtask

  initial begin
    error_cnt       = 0;
    sent_cnt        = 0;
    checked_cnt     = 0;
    off_nominal_cnt = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_nominal(700);
    test_no_idle(200);
    test_backpressure(40);
    test_random_wide(200);

    if (expected_rgb_q.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_rgb_q.size()));
    $display("sent %0d hsv transactions (%0d past 360 deg or above unity), checked %0d",
             sent_cnt, off_nominal_cnt, checked_cnt);
    $display("covered sector edges, random and idle-free streams, and output hold-off");
    if (error_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_if.sv
rtl/core/hsvrgb_hue_unit.sv
rtl/core/hsvrgb_chroma_unit.sv
rtl/core/hsvrgb_channel_unit.sv
rtl/core/hsv_to_rgb_converter.sv
sim/tb_top.sv
